// File: rtl/analog_input_averaging_registers_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the analog input averaging registers
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ANALOG_INPUT_AVERAGING_REGISTERS_MACROS_SVH
`define ANALOG_INPUT_AVERAGING_REGISTERS_MACROS_SVH

// The condition implies the expression in the same cycle.
`define AIAR_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the next cycle.
`define AIAR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: rtl/aiar_pkg.sv
// ----------------------------------------------------------------------------
// Analog input averaging registers package
// Command codes, register selects and controller/datapath interface types.
// ----------------------------------------------------------------------------
package aiar_pkg;

  localparam int DATA_W = 32;
  localparam int WIN_W  = 15;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_REG_READ = 2'd2,
    CMD_READ_OUT = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_OVERSAMPLE = 3'd0,
    REG_AVERAGE    = 3'd1,
    REG_SCAN       = 3'd2,
    REG_READ_CHAN  = 3'd3,
    REG_AVERAGED   = 3'd4
  } reg_code_t;

  typedef struct packed {
    logic accept;
    logic walk_en;
    logic div_start;
    logic take_sum;
    logic take_quot;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_empty;
    logic averaged;
    logic walk_done;
    logic div_done;
  } dp_status_t;

endpackage

// File: rtl/analog_input_averaging_registers.sv
// ----------------------------------------------------------------------------
// Analog input averaging registers
// Per-channel sample history with register access and windowed averaging.
// ----------------------------------------------------------------------------
// Channel   Valid      Stall      Word
// request   req_valid  req_stall  cmd, channel, reg_sel, data_in
// response  rsp_valid  rsp_stall  read_data
//
// Pushes and register writes complete when accepted; a register read is
// captured in the result register and then loaded into the output register.
// A read output of a channel that holds samples walks the history (one
// memory read per sample), then, when averaged, passes the sum through the
// divider, and then loads the output register.
// Reset clears pointers, fill counts and settings; the history is not cleared.
// The request side stalls while a read is in progress; a finished word waits
// in the output register while further items are accepted.
// ----------------------------------------------------------------------------
module analog_input_averaging_registers #(
  parameter int CHANNELS = 8,
  parameter int HISTORY  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         cmd,
  input  logic [2:0]         channel,
  input  logic [2:0]         reg_sel,
  input  logic signed [31:0] data_in,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] read_data
);

  aiar_pkg::dp_cmd_t    ctl;
  aiar_pkg::dp_status_t status;

  aiar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .item_cmd  (cmd),
    .status    (status),
    .ctl       (ctl)
  );

  aiar_dp #(
    .CHANNELS (CHANNELS),
    .HISTORY  (HISTORY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .status    (status),
    .item_cmd  (cmd),
    .channel   (channel),
    .reg_sel   (reg_sel),
    .data_in   (data_in),
    .read_data (read_data)
  );

endmodule

// File: rtl/aiar_div.sv
// ----------------------------------------------------------------------------
// Averaging divider
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module aiar_div #(
  parameter int W  = 37,
  parameter int DW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                done,
  output logic signed [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [W-1:0]     q;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [DW:0]      r_sh;
  logic [DW:0]      r_diff;
  logic             ge;
  logic [DW-1:0]    rem_next;

  always_comb begin
    r_sh     = {rem, q[W-1]};
    ge       = r_sh >= {1'b0, dsr};
    r_diff   = r_sh - {1'b0, dsr};
    rem_next = ge ? r_diff[DW-1:0] : r_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1];
      q   <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      q   <= {q[W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = neg ? (~q + 1'b1) : q;

endmodule

// File: rtl/aiar_dp.sv
// ----------------------------------------------------------------------------
// Analog input averaging datapath
// Channel settings, ring pointers, sample history memory, window
// accumulator, divider and result registers.
// ----------------------------------------------------------------------------
module aiar_dp #(
  parameter int CHANNELS = 8,
  parameter int HISTORY  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  aiar_pkg::dp_cmd_t     ctl,
  output aiar_pkg::dp_status_t  status,
  input  logic [1:0]            item_cmd,
  input  logic [2:0]            channel,
  input  logic [2:0]            reg_sel,
  input  logic signed [31:0]    data_in,
  output logic signed [31:0]    read_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int FILL_W = $clog2(HISTORY + 1);
  localparam int DEPTH  = CHANNELS * HISTORY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = aiar_pkg::DATA_W + FILL_W;
  localparam int WIN_W  = aiar_pkg::WIN_W;

  logic [POS_W-1:0]  wpos [CHANNELS];
  logic [FILL_W-1:0] fill [CHANNELS];
  logic [2:0]        ovs  [CHANNELS];
  logic [2:0]        avg  [CHANNELS];
  logic [7:0]        scan [CHANNELS];
  logic [2:0]        sel_chan;
  logic              averaged;

  logic [31:0]       hist_mem [DEPTH];
  logic signed [31:0] rdata;

  logic [CH_W-1:0]   cur_ch;
  logic [POS_W-1:0]  slot;
  logic [FILL_W-1:0] nreg;
  logic [FILL_W-1:0] issue_left;
  logic [FILL_W-1:0] acc_left;
  logic              rd_pend;
  logic signed [SUM_W-1:0] sum;
  logic [31:0]       result;

  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic              sc_ok;
  logic [CH_W-1:0]   sc_idx;
  logic [31:0]       reg_value;
  logic [POS_W-1:0]  newest;
  logic [3:0]        shift;
  logic [WIN_W-1:0]  win;
  logic [FILL_W-1:0] fill_sel;
  logic [FILL_W-1:0] n_sel;
  logic              push_we;
  logic              issue;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [POS_W-1:0]  wpos_inc;
  logic signed [SUM_W-1:0] quot;
  logic              div_done;

  always_comb begin
    ch_ok    = 32'(channel) < CHANNELS;
    ch_idx   = CH_W'(channel);
    sc_ok    = 32'(sel_chan) < CHANNELS;
    sc_idx   = CH_W'(sel_chan);
    fill_sel = fill[sc_idx];
    newest   = (wpos[sc_idx] == '0) ? POS_W'(HISTORY - 1) : wpos[sc_idx] - 1'b1;
    shift    = {1'b0, avg[sc_idx]} + {1'b0, ovs[sc_idx]};
    win      = WIN_W'(1) << shift;
    if (averaged) begin
      n_sel = (win < WIN_W'(fill_sel)) ? FILL_W'(win) : fill_sel;
    end else begin
      n_sel = FILL_W'(1);
    end
    wpos_inc = (wpos[ch_idx] == POS_W'(HISTORY - 1)) ? '0 : wpos[ch_idx] + 1'b1;
    push_we  = ctl.accept && (item_cmd == aiar_pkg::CMD_PUSH) && ch_ok;
    issue    = ctl.walk_en && (issue_left != '0);
    waddr    = ADDR_W'(ch_idx) * ADDR_W'(HISTORY) + ADDR_W'(wpos[ch_idx]);
    raddr    = ADDR_W'(cur_ch) * ADDR_W'(HISTORY) + ADDR_W'(slot);
    case (reg_sel)
      aiar_pkg::REG_OVERSAMPLE: reg_value = ch_ok ? 32'(ovs[ch_idx]) : '0;
      aiar_pkg::REG_AVERAGE:    reg_value = ch_ok ? 32'(avg[ch_idx]) : '0;
      aiar_pkg::REG_SCAN:       reg_value = ch_ok ? 32'(scan[ch_idx]) : '0;
      aiar_pkg::REG_READ_CHAN:  reg_value = 32'(sel_chan);
      aiar_pkg::REG_AVERAGED:   reg_value = 32'(averaged);
      default:                  reg_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      hist_mem[waddr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= hist_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wpos[i] <= '0;
        fill[i] <= '0;
        ovs[i]  <= '0;
        avg[i]  <= '0;
        scan[i] <= '0;
      end
      sel_chan   <= '0;
      averaged   <= 1'b0;
      issue_left <= '0;
      acc_left   <= '0;
      rd_pend    <= 1'b0;
    end else begin
      if (ctl.accept) begin
        case (item_cmd)
          aiar_pkg::CMD_PUSH: begin
            if (ch_ok) begin
              wpos[ch_idx] <= wpos_inc;
              if (fill[ch_idx] < FILL_W'(HISTORY)) begin
                fill[ch_idx] <= fill[ch_idx] + 1'b1;
              end
            end
          end
          aiar_pkg::CMD_WRITE: begin
            case (reg_sel)
              aiar_pkg::REG_OVERSAMPLE: if (ch_ok) ovs[ch_idx] <= data_in[2:0];
              aiar_pkg::REG_AVERAGE:    if (ch_ok) avg[ch_idx] <= data_in[2:0];
              aiar_pkg::REG_SCAN:       if (ch_ok) scan[ch_idx] <= data_in[7:0];
              aiar_pkg::REG_READ_CHAN:  sel_chan <= data_in[2:0];
              aiar_pkg::REG_AVERAGED:   averaged <= data_in[0];
              default: ;
            endcase
          end
          aiar_pkg::CMD_READ_OUT: begin
            issue_left <= n_sel;
            acc_left   <= n_sel;
          end
          default: ;
        endcase
      end
      rd_pend <= issue;
      if (issue) begin
        issue_left <= issue_left - 1'b1;
      end
      if (ctl.walk_en && rd_pend) begin
        acc_left <= acc_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && (item_cmd == aiar_pkg::CMD_READ_OUT)) begin
      cur_ch <= sc_idx;
      slot   <= newest;
      nreg   <= n_sel;
      sum    <= '0;
      result <= '0;
    end else begin
      if (issue) begin
        slot <= (slot == '0) ? POS_W'(HISTORY - 1) : slot - 1'b1;
      end
      if (ctl.walk_en && rd_pend) begin
        sum <= sum + SUM_W'(rdata);
      end
    end
    if (ctl.accept && (item_cmd == aiar_pkg::CMD_REG_READ)) begin
      result <= reg_value;
    end
    if (ctl.take_sum) begin
      result <= sum[31:0];
    end
    if (ctl.take_quot) begin
      result <= quot[31:0];
    end
    if (ctl.out_load) begin
      read_data <= result;
    end
  end

  aiar_div #(
    .W  (SUM_W),
    .DW (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (sum),
    .divisor  (nreg),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    status.rd_empty  = !sc_ok || (fill_sel == '0);
    status.averaged  = averaged;
    status.walk_done = (acc_left == '0);
    status.div_done  = div_done;
  end

endmodule

// File: rtl/aiar_ctrl.sv
// ----------------------------------------------------------------------------
// Analog input averaging controller
// Sequences item acceptance, the history walk, the divide and the
// response handshake.
// ----------------------------------------------------------------------------
module aiar_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic [1:0]           item_cmd,
  input  aiar_pkg::dp_status_t status,
  output aiar_pkg::dp_cmd_t    ctl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUT  = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;
  logic        rsp_valid_next;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        ctl.accept = accept;
        if (accept) begin
          case (item_cmd)
            aiar_pkg::CMD_REG_READ: state_next = ST_PUT;
            aiar_pkg::CMD_READ_OUT: state_next = status.rd_empty ? ST_PUT : ST_WALK;
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        ctl.walk_en = 1'b1;
        if (status.walk_done) begin
          if (status.averaged) begin
            ctl.div_start = 1'b1;
            state_next    = ST_DIV;
          end else begin
            ctl.take_sum = 1'b1;
            state_next   = ST_PUT;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          ctl.take_quot = 1'b1;
          state_next    = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!rsp_valid || !rsp_stall) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
    if (ctl.out_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: rtl/aiar_checker.sv
// ----------------------------------------------------------------------------
// Analog input averaging registers port checker
// Checks response holding, reset behavior and request sequencing.
// ----------------------------------------------------------------------------
`include "analog_input_averaging_registers_macros.svh"

module aiar_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic [1:0]         cmd,
  input logic [2:0]         channel,
  input logic [2:0]         reg_sel,
  input logic signed [31:0] data_in,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] read_data
);

  logic req_take;

  assign req_take = req_valid && !req_stall;

  `AIAR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(read_data), "Stalled response word changed.")
  `AIAR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !rsp_valid && !req_stall, "Block not idle after reset.")
  `AIAR_ASSERT_NEXT(a_push_quiet, clk, rst, req_take && !rsp_valid && (cmd == aiar_pkg::CMD_PUSH || cmd == aiar_pkg::CMD_WRITE), !rsp_valid, "Push or write produced a response word.")
  `AIAR_ASSERT_NEXT(a_read_busy, clk, rst, req_take && (cmd == aiar_pkg::CMD_REG_READ || cmd == aiar_pkg::CMD_READ_OUT), req_stall, "Read did not hold off the request side.")
  `AIAR_ASSERT_SAME(a_no_x_stall, clk, rst, 1'b1, !$isunknown(req_stall), "Request stall is unknown.")

endmodule

bind analog_input_averaging_registers aiar_checker u_aiar_checker (.*);
